FILE: design/lsfd_pkg.sv
// ----------------------------------------------------------------------------
// lsfd_pkg
// Shared types, constants and arithmetic helpers for the landing sensor
// frame decoder.
// ----------------------------------------------------------------------------
package lsfd_pkg;

  localparam int LSFD_FRAME_BYTES = 18;
  localparam int LSFD_STORE_BYTES = LSFD_FRAME_BYTES - 1;
  localparam int LSFD_IDX_W       = 5;
  localparam int LSFD_QUEUE_DEPTH = 2;

  localparam int LSFD_CFG_IDX_W  = 1;
  localparam int LSFD_CFG_DATA_W = 16;

  localparam logic [LSFD_CFG_IDX_W-1:0] CFG_GAIN_X = 1'd0;
  localparam logic [LSFD_CFG_IDX_W-1:0] CFG_GAIN_Y = 1'd1;

  localparam logic [15:0] GAIN_RESET = 16'd256;

  // One decoded frame (or failure event) on its way to the scaling stages.
  typedef struct packed {
    logic        frame_ok;
    logic [15:0] sensor_id;
    logic [15:0] status_word;
    logic [15:0] raw_pos_x;
    logic [15:0] raw_pos_y;
    logic [15:0] pos_z;
    logic [15:0] raw_vel_x;
    logic [15:0] raw_vel_y;
    logic [7:0]  snr;
    logic [7:0]  cl;
    logic [7:0]  sl;
    logic [15:0] failure_count;
  } frame_rec_t;

  // Round to nearest (halves up) after Q8.8 product, then clamp to 16 bits.
  function automatic logic [15:0] round_sat(input logic signed [31:0] p);
    logic signed [32:0] r;
    logic signed [24:0] q;
    logic [15:0]        res;
    r = {p[31], p} + 33'sd128;
    q = r[32:8];
    if (q > 25'sd32767) begin
      res = 16'h7FFF;
    end else if (q < -25'sd32768) begin
      res = 16'h8000;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

endpackage

FILE: design/lsfd_front.sv
// ----------------------------------------------------------------------------
// lsfd_front
// Byte intake: assembles the frame, keeps the running sum and the failure
// counter, and emits one record per frame end or transfer error.
// ----------------------------------------------------------------------------
module lsfd_front
  import lsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  logic       q_full,
  output logic       push,
  output frame_rec_t push_rec
);

  logic [LSFD_IDX_W-1:0] byte_index;
  logic [LSFD_IDX_W-1:0] byte_index_next;
  logic [7:0]            running_sum;
  logic [7:0]            running_sum_next;
  logic [15:0]           failures;
  logic [15:0]           failures_next;
  logic [7:0]            frame_store [LSFD_STORE_BYTES];

  logic                  accept;
  logic [LSFD_IDX_W-1:0] idx;
  logic [7:0]            sum;
  logic [15:0]           fail_bumped;
  logic                  store_we;

  assign in_stall    = q_full;
  assign accept      = in_valid && !in_stall;
  assign idx         = frame_start ? '0 : byte_index;
  assign sum         = frame_start ? 8'd0 : running_sum;
  assign fail_bumped = (failures == 16'hFFFF) ? failures : failures + 16'd1;

  always_comb begin
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    failures_next    = failures;
    store_we         = 1'b0;
    push             = 1'b0;
    push_rec         = '0;
    if (accept) begin
      if (func) begin
        // transfer error: drop the frame in progress and go idle
        failures_next          = fail_bumped;
        byte_index_next        = LSFD_IDX_W'(LSFD_FRAME_BYTES);
        push                   = 1'b1;
        push_rec.failure_count = fail_bumped;
      end else if (idx < LSFD_IDX_W'(LSFD_STORE_BYTES)) begin
        store_we         = 1'b1;
        running_sum_next = sum + data_byte;
        byte_index_next  = idx + 1'b1;
      end else if (idx == LSFD_IDX_W'(LSFD_STORE_BYTES)) begin
        byte_index_next = LSFD_IDX_W'(LSFD_FRAME_BYTES);
        push            = 1'b1;
        if (data_byte != sum) begin
          failures_next          = fail_bumped;
          push_rec.failure_count = fail_bumped;
        end else begin
          push_rec.frame_ok      = 1'b1;
          push_rec.sensor_id     = {frame_store[1], frame_store[0]};
          push_rec.status_word   = {frame_store[3], frame_store[2]};
          push_rec.raw_pos_y     = {frame_store[5], frame_store[4]};
          push_rec.raw_pos_x     = {frame_store[7], frame_store[6]};
          push_rec.pos_z         = {frame_store[9], frame_store[8]};
          push_rec.raw_vel_y     = {frame_store[11], frame_store[10]};
          push_rec.raw_vel_x     = {frame_store[13], frame_store[12]};
          push_rec.snr           = frame_store[14];
          push_rec.cl            = frame_store[15];
          push_rec.sl            = frame_store[16];
          push_rec.failure_count = failures;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_sum <= '0;
      failures    <= '0;
    end else begin
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      failures    <= failures_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[idx] <= data_byte;
    end
  end

`ifndef SYNTH
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= LSFD_IDX_W'(LSFD_FRAME_BYTES))
    else $error("frame byte index out of range");

  a_fail_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> failures >= $past(failures))
    else $error("failure counter went down");

  a_fail_push: assert property (@(posedge clk) disable iff (rst)
    accept && func |-> push && !push_rec.frame_ok)
    else $error("transfer error did not produce a failure record");
`endif

endmodule

FILE: design/lsfd_queue.sv
// ----------------------------------------------------------------------------
// lsfd_queue
// Small record FIFO between frame intake and the scaling pipeline.
// ----------------------------------------------------------------------------
module lsfd_queue
  import lsfd_pkg::*;
#(
  parameter int DEPTH = LSFD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output frame_rec_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("record pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: design/lsfd_back.sv
// ----------------------------------------------------------------------------
// lsfd_back
// Gain registers and two-stage scaling pipeline: multiply, then round,
// clamp and hold in the output register.
// ----------------------------------------------------------------------------
module lsfd_back
  import lsfd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [LSFD_CFG_IDX_W-1:0] cfg_index,
  input  logic [LSFD_CFG_DATA_W-1:0] cfg_data,
  input  logic                      head_valid,
  input  frame_rec_t                head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output frame_rec_t                out_rec
);

  logic [15:0]        gain_x;
  logic [15:0]        gain_y;

  logic               adv;
  logic               s1_valid;
  frame_rec_t         s1_rec;
  frame_rec_t         out_rec_next;
  logic signed [31:0] prod_pos_x;
  logic signed [31:0] prod_pos_y;
  logic signed [31:0] prod_vel_x;
  logic signed [31:0] prod_vel_y;

  // the whole pipeline advances together whenever the output can move
  assign adv = !out_valid || !out_stall;
  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x <= GAIN_RESET;
      gain_y <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAIN_X: gain_x <= cfg_data;
        CFG_GAIN_Y: gain_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= head_valid;
      out_valid <= s1_valid;
    end
  end

  always_comb begin
    out_rec_next           = s1_rec;
    out_rec_next.raw_pos_x = round_sat(prod_pos_x);
    out_rec_next.raw_pos_y = round_sat(prod_pos_y);
    out_rec_next.raw_vel_x = round_sat(prod_vel_x);
    out_rec_next.raw_vel_y = round_sat(prod_vel_y);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rec     <= head;
      prod_pos_x <= $signed(head.raw_pos_x) * $signed(gain_x);
      prod_pos_y <= $signed(head.raw_pos_y) * $signed(gain_y);
      prod_vel_x <= $signed(head.raw_vel_x) * $signed(gain_x);
      prod_vel_y <= $signed(head.raw_vel_y) * $signed(gain_y);
      out_rec    <= out_rec_next;
    end
  end

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rec.frame_ok |->
      out_rec.raw_pos_x == 16'd0 && out_rec.raw_vel_y == 16'd0 &&
      out_rec.sensor_id == 16'd0 && out_rec.snr == 8'd0)
    else $error("failure result carries nonzero fields");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid)
    else $error("popped record did not enter the multiply stage");
`endif

endmodule

FILE: design/landing_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// landing_sensor_frame_decoder
// Assembles 18-byte sensor frames, checks the additive checksum and outputs
// decoded, gain-scaled fields with a saturating failure count.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   in       in_valid / in_stall   func, data_byte, frame_start
//   out      out_valid / out_stall frame_ok .. failure_count (12 fields)
//   cfg      cfg_write             cfg_index, cfg_data (gain_x, gain_y)
//
// One byte is taken per cycle; intake stalls only while the record queue
// is full. A frame's result passes through the queue entry, which is written
// on the edge that takes its last byte, then the multiply stage and then
// the round/clamp output register.
// rst is synchronous: index, sum and failure count clear, gains go to 1.0.
// out_stall freezes the output register and the multiply stage together while out_valid is high.
// ----------------------------------------------------------------------------
module landing_sensor_frame_decoder
  import lsfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = LSFD_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [LSFD_CFG_IDX_W-1:0]  cfg_index,
  input  logic [LSFD_CFG_DATA_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [7:0]                 data_byte,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       frame_ok,
  output logic [15:0]                sensor_id,
  output logic [15:0]                status_word,
  output logic signed [15:0]         pos_x,
  output logic signed [15:0]         pos_y,
  output logic signed [15:0]         pos_z,
  output logic signed [15:0]         vel_x,
  output logic signed [15:0]         vel_y,
  output logic [7:0]                 snr,
  output logic [7:0]                 cl,
  output logic [7:0]                 sl,
  output logic [15:0]                failure_count
);

  logic       q_full;
  logic       push;
  frame_rec_t push_rec;
  logic       pop;
  logic       head_valid;
  frame_rec_t head;
  frame_rec_t out_rec;

  lsfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  lsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lsfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rec    (out_rec)
  );

  assign frame_ok      = out_rec.frame_ok;
  assign sensor_id     = out_rec.sensor_id;
  assign status_word   = out_rec.status_word;
  assign pos_x         = out_rec.raw_pos_x;
  assign pos_y         = out_rec.raw_pos_y;
  assign pos_z         = out_rec.pos_z;
  assign vel_x         = out_rec.raw_vel_x;
  assign vel_y         = out_rec.raw_vel_y;
  assign snr           = out_rec.snr;
  assign cl            = out_rec.cl;
  assign sl            = out_rec.sl;
  assign failure_count = out_rec.failure_count;

endmodule
